@@ rtl/core/bsae_pkg.sv @@
// Package for the byte set algebra engine.
// Holds the request and response beat types, operation and status codes,
// and the control types shared by the cell row and the top level.
package bsae_pkg;

   typedef struct packed {
      logic [2:0] operation;
      logic       target_set;
      logic [7:0] element;
   } req_type;

   typedef struct packed {
      logic [7:0] out_element;
      logic       element_valid;
      logic       last;
      logic       flag;
      logic [1:0] status;
   } rsp_type;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_POP    = 3'd1;
   localparam logic [2:0] OP_INTER  = 3'd2;
   localparam logic [2:0] OP_UNION  = 3'd3;
   localparam logic [2:0] OP_DIFF   = 3'd4;
   localparam logic [2:0] OP_SUBSET = 3'd5;
   localparam logic [2:0] OP_EQUAL  = 3'd6;
   localparam logic [2:0] OP_CLEAR  = 3'd7;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef logic [1:0] row_cmd_type;

   localparam row_cmd_type ROW_HOLD = 2'd0;
   localparam row_cmd_type ROW_PUSH = 2'd1;
   localparam row_cmd_type ROW_POP  = 2'd2;
   localparam row_cmd_type ROW_ROT  = 2'd3;

   typedef struct packed {
      row_cmd_type cmd;
      logic [7:0]  key;
   } row_ctrl_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] top_data;
      logic [7:0] low_data;
   } row_stat_type;

endpackage

@@ rtl/core/byte_set_algebra_engine.sv @@
// Top level of the byte set algebra engine: two cell rows and the sequencer.
// Depends on bsae_pkg and bsae_row.
//
//   channel   ports                          handshake
//   request   start, busy, req_item          start high while busy low
//   result    rsp_valid, rsp_item            one-cycle strobe, no backpressure
//
// Insert, pop and clear: the membership compare of every cell
// is registered at the accepting edge and the decision follows.
// Intersection, difference, subset and equality rotate the operand row one
// cell per cycle through a full pass; union makes a second pass over the
// other row. Each response beat is registered. Reset empties both sets
// at once; there is no clearing pass. The receiver cannot stall the block.
module byte_set_algebra_engine #(
   parameter int CAPACITY = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bsae_pkg::req_type req_item,
   output logic              rsp_valid,
   output bsae_pkg::rsp_type rsp_item
);

   localparam int CntW  = $clog2(CAPACITY + 1);
   localparam int StepW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DEC   = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   logic              sel_ff, sel_in;
   logic [7:0]        elem_ff, elem_in;
   logic              phase_ff, phase_in;
   logic [StepW-1:0]  step_ff, step_in;
   logic [CntW-1:0]   cnt_ff [2];
   logic [CntW-1:0]   cnt_in [2];
   logic              sub_ff, sub_in;
   logic              pend_v_ff, pend_v_in;
   logic [7:0]        pend_ff, pend_in;
   logic              s1_v_ff, s1_v_in;
   logic [7:0]        s1_data_ff, s1_data_in;
   logic              s1_row_ff, s1_row_in;
   logic              s1_uncond_ff, s1_uncond_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bsae_pkg::rsp_type rsp_ff, rsp_in;

   bsae_pkg::row_ctrl_type ctrl [2];
   bsae_pkg::row_stat_type stat [2];

   logic       rot_row;
   logic [7:0] key;
   logic       hit1;
   logic       keep;

   for (genvar g = 0; g < 2; g++) begin : g_row
      bsae_row #(
         .CAPACITY (CAPACITY)
      ) u_row (
         .clock (clock),
         .ctrl  (ctrl[g]),
         .count (cnt_ff[g]),
         .stat  (stat[g])
      );
   end

   assign rot_row = phase_ff ? !sel_ff : sel_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      sel_in       = sel_ff;
      elem_in      = elem_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      cnt_in[0]    = cnt_ff[0];
      cnt_in[1]    = cnt_ff[1];
      sub_in       = sub_ff;
      pend_v_in    = pend_v_ff;
      pend_in      = pend_ff;
      s1_v_in      = 1'b0;
      s1_data_in   = stat[rot_row].top_data;
      s1_row_in    = !rot_row;
      s1_uncond_in = !phase_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      key          = elem_ff;
      ctrl[0].cmd  = bsae_pkg::ROW_HOLD;
      ctrl[1].cmd  = bsae_pkg::ROW_HOLD;

      hit1 = stat[s1_row_ff].hit;
      case (op_ff)
         bsae_pkg::OP_INTER: keep = hit1;
         bsae_pkg::OP_DIFF:  keep = !hit1;
         bsae_pkg::OP_UNION: keep = s1_uncond_ff || !hit1;
         default:            keep = 1'b0;
      endcase

      if (s1_v_ff) begin
         if ((op_ff == bsae_pkg::OP_SUBSET || op_ff == bsae_pkg::OP_EQUAL) && !hit1) begin
            sub_in = 1'b0;
         end
         if (keep) begin
            if (pend_v_ff) begin
               rsp_valid_in         = 1'b1;
               rsp_in.out_element   = pend_ff;
               rsp_in.element_valid = 1'b1;
            end
            pend_in   = s1_data_ff;
            pend_v_in = 1'b1;
         end
      end

      case (state_ff)
         S_IDLE: begin
            key = req_item.element;
            if (start) begin
               op_in     = req_item.operation;
               sel_in    = req_item.target_set;
               elem_in   = req_item.element;
               phase_in  = 1'b0;
               step_in   = '0;
               sub_in    = 1'b1;
               pend_v_in = 1'b0;
               if (req_item.operation inside {bsae_pkg::OP_INSERT, bsae_pkg::OP_POP,
                                              bsae_pkg::OP_CLEAR}) begin
                  state_in = S_DEC;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_DEC: begin
            rsp_valid_in = 1'b1;
            rsp_in.last  = 1'b1;
            case (op_ff)
               bsae_pkg::OP_INSERT: begin
                  if (stat[sel_ff].hit) begin
                     rsp_in.status = bsae_pkg::STATUS_OK;
                  end else if (cnt_ff[sel_ff] == CntW'(CAPACITY)) begin
                     rsp_in.status = bsae_pkg::STATUS_FULL;
                  end else begin
                     ctrl[sel_ff].cmd = bsae_pkg::ROW_PUSH;
                     cnt_in[sel_ff]   = CntW'(cnt_ff[sel_ff] + 1'b1);
                     rsp_in.flag      = 1'b1;
                  end
               end
               bsae_pkg::OP_POP: begin
                  if (cnt_ff[sel_ff] == '0) begin
                     rsp_in.status = bsae_pkg::STATUS_EMPTY;
                  end else begin
                     ctrl[sel_ff].cmd     = bsae_pkg::ROW_POP;
                     cnt_in[sel_ff]       = CntW'(cnt_ff[sel_ff] - 1'b1);
                     rsp_in.out_element   = stat[sel_ff].low_data;
                     rsp_in.element_valid = 1'b1;
                  end
               end
               bsae_pkg::OP_CLEAR: begin
                  cnt_in[sel_ff] = '0;
               end
               default: begin
               end
            endcase
            state_in = S_IDLE;
         end
         S_SCAN: begin
            key           = stat[rot_row].top_data;
            ctrl[rot_row].cmd = bsae_pkg::ROW_ROT;
            s1_v_in       = ((CntW+1)'(step_ff) + (CntW+1)'(cnt_ff[rot_row]))
                            >= (CntW+1)'(CAPACITY);
            step_in       = StepW'(step_ff + 1'b1);
            if (step_ff == StepW'(CAPACITY - 1)) begin
               step_in = '0;
               if (!phase_ff && op_ff == bsae_pkg::OP_UNION) begin
                  phase_in = 1'b1;
               end else begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            state_in = S_FLUSH;
         end
         S_FLUSH: begin
            rsp_valid_in = 1'b1;
            rsp_in.last  = 1'b1;
            if (op_ff == bsae_pkg::OP_SUBSET || op_ff == bsae_pkg::OP_EQUAL) begin
               rsp_in.flag = sub_ff && (op_ff != bsae_pkg::OP_EQUAL || cnt_ff[0] == cnt_ff[1]);
            end else if (pend_v_ff) begin
               rsp_in.out_element   = pend_ff;
               rsp_in.element_valid = 1'b1;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      ctrl[0].key = key;
      ctrl[1].key = key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff[0]    <= '0;
         cnt_ff[1]    <= '0;
         pend_v_ff    <= 1'b0;
         s1_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         op_ff        <= bsae_pkg::OP_INSERT;
         phase_ff     <= 1'b0;
         step_ff      <= '0;
         sub_ff       <= 1'b1;
      end else begin
         state_ff     <= state_in;
         cnt_ff[0]    <= cnt_in[0];
         cnt_ff[1]    <= cnt_in[1];
         pend_v_ff    <= pend_v_in;
         s1_v_ff      <= s1_v_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         sub_ff       <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff       <= sel_in;
      elem_ff      <= elem_in;
      pend_ff      <= pend_in;
      s1_data_ff   <= s1_data_in;
      s1_row_ff    <= s1_row_in;
      s1_uncond_ff <= s1_uncond_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[0] <= CntW'(CAPACITY) && cnt_ff[1] <= CntW'(CAPACITY))
      else $error("set count exceeds capacity");

   a_idle_pipe: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !s1_v_ff)
      else $error("compare stage holds an element while idle");

   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FLUSH |=> rsp_valid && rsp_item.last)
      else $error("final beat missing after flush");

   a_dec_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DEC |=> rsp_valid && rsp_item.last && !busy)
      else $error("single-beat operation did not finish");

endmodule

@@ rtl/core/bsae_cell.sv @@
// One storage cell of a set row: holds one byte and a registered match bit.
// Depends on bsae_pkg for the row command codes.
module bsae_cell (
   input  logic                  clock,
   input  bsae_pkg::row_cmd_type cmd,
   input  logic [7:0]            key,
   input  logic [7:0]            up_data,
   input  logic [7:0]            dn_data,
   input  logic                  occ,
   output logic [7:0]            data,
   output logic                  match
);

   logic [7:0] data_ff;
   logic [7:0] data_in;
   logic       match_ff;
   logic       match_in;

   always_comb begin
      case (cmd)
         bsae_pkg::ROW_PUSH, bsae_pkg::ROW_ROT: begin
            data_in = up_data;
         end
         bsae_pkg::ROW_POP: begin
            data_in = dn_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
      match_in = occ && (data_ff == key);
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

@@ rtl/core/bsae_row.sv @@
// A row of cells holding one set, newest byte in cell zero.
// Depends on bsae_pkg and bsae_cell.
module bsae_row #(
   parameter int CAPACITY = 32
) (
   input  logic                          clock,
   input  bsae_pkg::row_ctrl_type        ctrl,
   input  logic [$clog2(CAPACITY+1)-1:0] count,
   output bsae_pkg::row_stat_type        stat
);

   localparam int CntW = $clog2(CAPACITY + 1);

   logic [7:0]          data [CAPACITY];
   logic [7:0]          up_data [CAPACITY];
   logic [7:0]          dn_data [CAPACITY];
   logic [CAPACITY-1:0] occ;
   logic [CAPACITY-1:0] match;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign occ[i] = CntW'(i) < count;

      if (i == 0) begin : g_first
         assign up_data[i] = (ctrl.cmd == bsae_pkg::ROW_PUSH) ? ctrl.key
                                                               : data[CAPACITY-1];
      end else begin : g_next
         assign up_data[i] = data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign dn_data[i] = data[i];
      end else begin : g_mid
         assign dn_data[i] = data[i+1];
      end

      bsae_cell u_cell (
         .clock   (clock),
         .cmd     (ctrl.cmd),
         .key     (ctrl.key),
         .up_data (up_data[i]),
         .dn_data (dn_data[i]),
         .occ     (occ[i]),
         .data    (data[i]),
         .match   (match[i])
      );
   end

   assign stat.hit      = |match;
   assign stat.top_data = data[CAPACITY-1];
   assign stat.low_data = data[0];

endmodule
